// ===== hw/rtl/u8wf_pkg.sv =====
// u8wf_pkg: shared types, code points and folding functions of the utf-8 word folder
// no dependencies; used by u8wf_fold and utf8_word_folder_core
package u8wf_pkg;

   // lead byte classes
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_VAL  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_VAL  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_VAL  = 8'hF0;
   localparam logic [7:0] LEAD2_PAYLOAD = 8'h1F;
   localparam logic [7:0] LEAD3_PAYLOAD = 8'h0F;
   localparam logic [7:0] CONT_PAYLOAD  = 8'h3F;

   // single byte handling
   localparam logic [7:0] BYTE_SOFT_HYPHEN = 8'hAD;
   localparam logic [7:0] ASCII_UPPER_A    = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z    = 8'h5A;
   localparam logic [7:0] ASCII_CASE_OFS   = 8'h20;

   // code points that are dropped or folded
   localparam logic [15:0] CP_SOFT_HYPHEN = 16'h00AD;
   localparam logic [15:0] CP_NONCHAR_FFFE = 16'hFFFE;
   localparam logic [15:0] CP_NONCHAR_FFFF = 16'hFFFF;
   localparam logic [15:0] CP_LSQUO       = 16'h2018;
   localparam logic [15:0] CP_RSQUO       = 16'h2019;
   localparam logic [15:0] CP_LDQUO       = 16'h201C;
   localparam logic [15:0] CP_RDQUO       = 16'h201D;
   localparam logic [15:0] CP_EN_DASH     = 16'h2013;
   localparam logic [15:0] CP_EM_DASH     = 16'h2014;

   localparam logic [7:0] ASCII_APOS   = 8'h27;
   localparam logic [7:0] ASCII_QUOTE  = 8'h22;
   localparam logic [7:0] ASCII_HYPHEN = 8'h2D;

   // up to four folded bytes and how many are meaningful
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } fold_out_type;

   // bytes held for an open multi-byte sequence
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic [2:0]      seq_len;
   } pend_type;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      if ((b & LEAD2_MASK) == LEAD2_VAL) len = 3'd2;
      else if ((b & LEAD3_MASK) == LEAD3_VAL) len = 3'd3;
      else if ((b & LEAD4_MASK) == LEAD4_VAL) len = 3'd4;
      else len = 3'd1;
      return len;
   endfunction

   function automatic fold_out_type fold_single(input logic [7:0] b);
      fold_out_type r;
      r = '0;
      if (b != BYTE_SOFT_HYPHEN) begin
         r.bytes[0] = (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) ? b + ASCII_CASE_OFS : b;
         r.count    = 3'd1;
      end
      return r;
   endfunction

   // complete sequence of len bytes (2..4) in w[0..len-1]
   function automatic fold_out_type fold_sequence(input logic [3:0][7:0] w,
                                                   input logic [2:0]      len);
      fold_out_type r;
      logic [15:0]  code;
      r    = '0;
      code = {8'h00, w[0]};
      if (len == 3'd2) begin
         code = {5'b0, w[0][4:0], w[1][5:0]};
      end else if (len == 3'd3) begin
         code = {w[0][3:0], w[1][5:0], w[2][5:0]};
      end
      case (code)
         CP_SOFT_HYPHEN, CP_NONCHAR_FFFE, CP_NONCHAR_FFFF: begin
            r.count = 3'd0;
         end
         CP_LSQUO, CP_RSQUO: begin
            r.bytes[0] = ASCII_APOS;
            r.count    = 3'd1;
         end
         CP_LDQUO, CP_RDQUO: begin
            r.bytes[0] = ASCII_QUOTE;
            r.count    = 3'd1;
         end
         CP_EN_DASH, CP_EM_DASH: begin
            r.bytes[0] = ASCII_HYPHEN;
            r.count    = 3'd1;
         end
         default: begin
            r.bytes = w;
            r.count = len;
         end
      endcase
      return r;
   endfunction

   // rescan of the last n bytes (1..4) of a word
   function automatic fold_out_type fold_tail(input logic [3:0][7:0] w,
                                               input logic [2:0]      n);
      fold_out_type    r;
      fold_out_type    part;
      logic [3:0][7:0] win;
      logic [2:0]      i;
      logic [2:0]      len;
      logic [2:0]      pos;
      r = '0;
      i = 3'd0;
      for (int s = 0; s < 4; s++) begin
         if (i < n) begin
            for (int k = 0; k < 4; k++) begin
               pos    = i + 3'(k);
               win[k] = (pos < 3'd4) ? w[pos[1:0]] : 8'h00;
            end
            len = lead_len(win[0]);
            if (len > 3'd1 && (i + len) <= n) begin
               part = fold_sequence(win, len);
               i    = i + len;
            end else begin
               part = fold_single(win[0]);
               i    = i + 3'd1;
            end
            for (int k = 0; k < 4; k++) begin
               if (3'(k) < part.count) begin
                  r.bytes[r.count[1:0] + 2'(k)] = part.bytes[k];
               end
            end
            r.count = r.count + part.count;
         end
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/u8wf_fold.sv =====
// u8wf_fold: combinational fold of one input byte against the held sequence bytes
// depends on u8wf_pkg (types and folding functions)
module u8wf_fold
   import u8wf_pkg::*;
(
   input  logic [7:0]   in_byte,
   input  logic         word_end,
   input  pend_type     pend,
   output pend_type     pend_next,
   output fold_out_type result
);

   logic [3:0][7:0] seq;
   logic [2:0]      seq_n;
   logic [2:0]      len;

   always_comb begin
      // held bytes followed by the new byte
      for (int k = 0; k < 3; k++) begin
         seq[k] = (2'(k) == pend.count) ? in_byte : pend.bytes[k];
      end
      seq[3] = in_byte;
      seq_n  = {1'b0, pend.count} + 3'd1;
      len    = lead_len(in_byte);

      pend_next = pend;
      result    = '0;

      if (word_end) begin
         result            = fold_tail(seq, seq_n);
         pend_next.count   = 2'd0;
         pend_next.seq_len = 3'd0;
      end else if (pend.seq_len != 3'd0) begin
         if (seq_n >= pend.seq_len || pend.count == 2'd3) begin
            result            = fold_sequence(seq, seq_n);
            pend_next.count   = 2'd0;
            pend_next.seq_len = 3'd0;
         end else begin
            for (int k = 0; k < 3; k++) begin
               if (2'(k) == pend.count) pend_next.bytes[k] = in_byte;
            end
            pend_next.count = pend.count + 2'd1;
         end
      end else if (len > 3'd1) begin
         pend_next.bytes[0] = in_byte;
         pend_next.count    = 2'd1;
         pend_next.seq_len  = len;
      end else begin
         result = fold_single(in_byte);
      end
   end

endmodule

// ===== hw/rtl/utf8_word_folder_core.sv =====
// utf8_word_folder_core: utf-8 word folder, byte stream in, folded byte stream out
// depends on u8wf_pkg and u8wf_fold
//
//  channel | direction | tdata              | tuser                         | tlast
//  --------+-----------+--------------------+-------------------------------+----------
//  req     | in        | [7:0] in_byte      | -                             | word_end
//  rsp     | out       | [7:0] out_byte     | [0] byte_valid, [1] run_last  | word_done
//
// one input beat is folded in the cycle it is accepted and its results (zero to four
// beats) are written into the result buffer; the buffer drains one beat per cycle while rsp_tready is high
// a beat that yields at most one result is taken every cycle while rsp_tready is high;
// a beat yielding more results holds req_tready low while the buffer drains
// the next beat is taken in the same cycle the last buffered result leaves
// reset clears the held sequence and empties the result buffer
// rsp_tready low stalls the buffer and, once it is full, the input side
module utf8_word_folder_core
   import u8wf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input byte stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // word_end
   // folded byte stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] run_last
   output logic       rsp_tlast    // word_done
);

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      total;     // beats in this run, 1..4
      logic            marker;    // bare word-end beat, no byte
      logic            word_end;
   } res_buf_type;

   // held sequence state
   pend_type     pend_ff;
   pend_type     pend_in;
   fold_out_type fold_res;

   // result buffer
   res_buf_type  res_ff;
   res_buf_type  res_in;
   logic [1:0]   idx_ff;
   logic [1:0]   idx_in;
   logic         valid_ff;
   logic         valid_in;

   logic         last_beat;
   logic         req_accept;
   logic         rsp_accept;
   logic         load;

   u8wf_fold u_fold (
      .in_byte   (req_tdata),
      .word_end  (req_tlast),
      .pend      (pend_ff),
      .pend_next (pend_in),
      .result    (fold_res)
   );

   // last beat of the buffered run
   assign last_beat  = valid_ff && (({1'b0, idx_ff} + 3'd1) == res_ff.total);
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // free when empty or when the final beat leaves this cycle
   assign req_tready = !valid_ff || (rsp_tready && last_beat);
   assign req_accept = req_tvalid && req_tready;

   // a beat with no surviving byte loads only if it ends the word (bare marker)
   assign load = req_accept && (fold_res.count != 3'd0 || req_tlast);

   always_comb begin
      res_in.bytes    = fold_res.bytes;
      res_in.marker   = (fold_res.count == 3'd0);
      res_in.total    = res_in.marker ? 3'd1 : fold_res.count;
      res_in.word_end = req_tlast;

      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (rsp_accept) begin
         if (last_beat) valid_in = 1'b0;
         else idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (req_accept) begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (load) res_ff <= res_in;
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = res_ff.marker ? 8'h00 : res_ff.bytes[idx_ff];
   assign rsp_tuser[0] = !res_ff.marker;
   assign rsp_tuser[1] = last_beat;
   assign rsp_tlast    = res_ff.word_end && last_beat;

   // a bare marker always closes both the run and the word
   a_marker_ends_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tlast && rsp_tuser[1]))
      else $error("bare marker beat without word end");

   // word end flushes the held sequence
   a_word_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=>
         (pend_ff.count == 2'd0 && pend_ff.seq_len == 3'd0))
      else $error("held bytes survive word end");

   // read pointer stays inside the buffered run
   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({1'b0, idx_ff} < res_ff.total))
      else $error("result index past run length");

   // word_done only on the final beat of a run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[1])
      else $error("word end before last beat of run");

endmodule

// ===== dv/utf8_word_folder_core_tb.sv =====
// utf8_word_folder_core_tb: self-checking bench for the utf-8 word folder core
// folds every accepted byte in a behavioral predictor and checks each result beat in order
// depends on u8wf_pkg (code points, lead masks) and the utf8_word_folder_core rtl
`timescale 1ns / 100ps

module utf8_word_folder_core_tb;
   import u8wf_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 8;
   // longest legal quiet spell is one sender gap or receiver stall,
   // so this limit is many times over it
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_BYTES = 175;
   localparam int STREAM_BYTES = 60;

   // one expected result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       word_done;
      logic       run_last;
   } folded_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       req_tlast = 1'b0;    // word_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic [1:0] rsp_tuser;           // [0] byte_valid, [1] run_last
   logic       rsp_tlast;           // word_done

   // predictor state: bytes held for an open multi-byte sequence
   logic [7:0]      held_bytes [3];
   int              held_count = 0;
   int              open_len = 0;
   logic [7:0]      fold_buf [$];
   folded_beat_type folded_beats_due [$];

   logic [7:0] word_bytes [$];
   int         bytes_sent = 0;
   int         error_count = 0;
   int         idle_cycles = 0;
   int         rsp_hold_left = 0;
   bit         calm = 1'b0;         // no idling on either side once set

   always #HALF_PERIOD clock = ~clock;

   utf8_word_folder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // length of the sequence a byte opens, 1 for anything that is not a lead
   function automatic int seq_length(input logic [7:0] b);
      if ((b & LEAD2_MASK) == LEAD2_VAL) return 2;
      if ((b & LEAD3_MASK) == LEAD3_VAL) return 3;
      if ((b & LEAD4_MASK) == LEAD4_VAL) return 4;
      return 1;
   endfunction

   // append one folded byte to the current run
   task fold_emit(input logic [7:0] v);
      fold_buf = {fold_buf, v};
   endtask

   // lone byte: soft hyphen byte vanishes, capitals are lowered
   task fold_lone(input logic [7:0] b);
      logic [7:0] lowered;
      if (b == BYTE_SOFT_HYPHEN) return;
      lowered = b + ASCII_CASE_OFS;
      if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) fold_emit(lowered);
      else fold_emit(b);
   endtask

   // complete sequence of len bytes in w[0..len-1]; 4-byte ones are never decoded
   task fold_cluster(input logic [3:0][7:0] w, input int len);
      logic [15:0] cp;
      case (len)
         2:       cp = {5'd0, w[0][4:0], w[1][5:0]};
         3:       cp = {w[0][3:0], w[1][5:0], w[2][5:0]};
         default: cp = {8'h00, w[0]};
      endcase
      if (cp == CP_SOFT_HYPHEN || cp == CP_NONCHAR_FFFE || cp == CP_NONCHAR_FFFF) begin
         return;
      end else if (cp == CP_LSQUO || cp == CP_RSQUO) begin
         fold_emit(ASCII_APOS);
      end else if (cp == CP_LDQUO || cp == CP_RDQUO) begin
         fold_emit(ASCII_QUOTE);
      end else if (cp == CP_EN_DASH || cp == CP_EM_DASH) begin
         fold_emit(ASCII_HYPHEN);
      end else begin
         for (int k = 0; k < len; k++) fold_emit(w[k]);
      end
   endtask

   // word end: rescan the held bytes plus the last one; a lead that does not
   // fit is taken alone and the scan moves on by one byte
   task fold_word_tail(input logic [3:0][7:0] w, input int n);
      int i;
      int len;
      i = 0;
      while (i < n) begin
         len = seq_length(w[i]);
         if (len > 1 && i + len <= n) begin
            fold_cluster(w >> (8 * i), len);
            i = i + len;
         end else begin
            fold_lone(w[i]);
            i = i + 1;
         end
      end
   endtask

   // advance the predictor by one accepted beat and queue its results
   task predict_folding(input logic [7:0] b, input logic word_end);
      logic [3:0][7:0] grp;
      folded_beat_type beat;
      fold_buf.delete();
      grp = '0;
      for (int k = 0; k < held_count; k++) grp[k] = held_bytes[k];
      grp[held_count] = b;
      if (word_end) begin
         fold_word_tail(grp, held_count + 1);
         held_count = 0;
         open_len   = 0;
      end else if (open_len != 0) begin
         if (held_count + 1 >= open_len || held_count >= 3) begin
            fold_cluster(grp, held_count + 1);
            held_count = 0;
            open_len   = 0;
         end else begin
            held_bytes[held_count] = b;
            held_count = held_count + 1;
         end
      end else if (seq_length(b) > 1) begin
         held_bytes[0] = b;
         held_count    = 1;
         open_len      = seq_length(b);
      end else begin
         fold_lone(b);
      end

      if (fold_buf.size() == 0) begin
         // bare end marker when a word ends with nothing left to send
         if (word_end) begin
            beat = '{out_byte: 8'h00, byte_valid: 1'b0, word_done: 1'b1, run_last: 1'b1};
            folded_beats_due = {folded_beats_due, beat};
         end
      end else begin
         for (int k = 0; k < fold_buf.size(); k++) begin
            beat.out_byte   = fold_buf[k];
            beat.byte_valid = 1'b1;
            beat.run_last   = (k == fold_buf.size() - 1);
            beat.word_done  = word_end && beat.run_last;
            folded_beats_due = {folded_beats_due, beat};
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // monitor: input acceptance feeds the predictor, output beats are checked,
   // and the watchdog counts cycles with no beat moving on either side
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      folded_beat_type due;
      logic            moved;
      moved = 1'b0;
      if (reset) begin
         held_count = 0;
         open_len   = 0;
      end else begin
         // predict first so a same-cycle result would still find its expectation
         if (req_tvalid && req_tready) begin
            predict_folding(req_tdata, req_tlast);
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (folded_beats_due.size() == 0) begin
               $error("unexpected result beat: out_byte %h byte_valid %b", rsp_tdata,
                      rsp_tuser[0]);
               error_count++;
            end else begin
               due = folded_beats_due.pop_front();
               if (rsp_tdata !== due.out_byte) begin
                  $error("out_byte: expected %h, got %h", due.out_byte, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser[0] !== due.byte_valid) begin
                  $error("byte_valid: expected %b, got %b", due.byte_valid, rsp_tuser[0]);
                  error_count++;
               end
               if (rsp_tlast !== due.word_done) begin
                  $error("word_done: expected %b, got %b", due.word_done, rsp_tlast);
                  error_count++;
               end
               if (rsp_tuser[1] !== due.run_last) begin
                  $error("run_last: expected %b, got %b", due.run_last, rsp_tuser[1]);
                  error_count++;
               end
            end
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // receiver: ready drops in random bursts, stays up once calm
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 7) == 0) rsp_hold_left = $urandom_range(1, 10);
      end
   end

   // ---------------------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------------------

   // one input beat, sometimes after a random idle gap
   task send_byte(input logic [7:0] value, input logic is_last);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // sends the collected word, end flag on its final byte
   task send_word();
      for (int i = 0; i < word_bytes.size(); i++) begin
         send_byte(word_bytes[i], i == word_bytes.size() - 1);
      end
      word_bytes.delete();
   endtask

   // append one byte to the word being built
   task word_add(input logic [7:0] v);
      word_bytes = {word_bytes, v};
   endtask

   task push_code_point(input logic [15:0] cp);
      if (cp < 16'h0800) begin
         word_add({3'b110, cp[10:6]});
      end else begin
         word_add({4'hE, cp[15:12]});
         word_add({2'b10, cp[11:6]});
      end
      word_add({2'b10, cp[5:0]});
   endtask

   // one random piece of a word, mostly well-formed text with some noise
   task add_random_piece();
      logic [15:0] specials [9];
      int          pick;
      specials = '{CP_LSQUO, CP_RSQUO, CP_LDQUO, CP_RDQUO, CP_EN_DASH, CP_EM_DASH,
                   CP_SOFT_HYPHEN, CP_NONCHAR_FFFE, CP_NONCHAR_FFFF};
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1: begin
            // letters of either case
            word_add(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25)));
         end
         2, 3: begin
            // the folded and dropped code points
            push_code_point(specials[$urandom_range(0, 8)]);
         end
         4: begin
            word_add({3'b110, 5'($urandom)});
            word_add({2'b10, 6'($urandom)});
         end
         5: begin
            word_add({4'hE, 4'($urandom)});
            word_add({2'b10, 6'($urandom)});
            word_add({2'b10, 6'($urandom)});
         end
         6: begin
            word_add({5'b11110, 3'($urandom)});
            repeat (3) word_add({2'b10, 6'($urandom)});
         end
         7: begin
            // noise: any byte, lone soft hyphen byte included
            word_add(8'($urandom));
            if ($urandom_range(0, 2) == 0) word_add(BYTE_SOFT_HYPHEN);
         end
         8: begin
            word_add(8'($urandom_range(8'h20, 8'h7E)));
         end
         default: begin
            // lead byte followed by one arbitrary byte, not checked as a continuation
            word_add(8'($urandom_range(8'hC0, 8'hF7)));
            word_add(8'($urandom));
         end
      endcase
   endtask

   // random words until the byte budget is spent; some are cut mid-sequence
   task run_random_words(input int budget);
      int stop_at;
      int pieces;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         pieces = $urandom_range(1, 6);
         repeat (pieces) add_random_piece();
         if (word_bytes.size() > 1 && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, (word_bytes.size() > 2) ? 2 : 1)) void'(word_bytes.pop_back());
         end
         send_word();
      end
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   task test_directed();
      // case fold edges and stray low and high bytes
      word_bytes = '{8'h41, 8'h5A, 8'h5B, 8'h00, 8'hFF};
      send_word();
      // quote, soft hyphen and noncharacter drops, a stray continuation,
      // and a dash that completes on the word end byte
      word_bytes = '{8'hE2, 8'h80, 8'h98, 8'hC2, 8'hAD, 8'hEF, 8'hBF, 8'hBE, 8'h80,
                     8'hE2, 8'h80, 8'h94};
      send_word();
      // word of one soft hyphen byte leaves only the end marker
      word_bytes = '{BYTE_SOFT_HYPHEN};
      send_word();
      // 4-byte sequence passes through, 2-byte sequence decoded in the tail
      word_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC3, 8'hA9};
      send_word();
      // sequence cut by the word end: lead goes out alone
      word_bytes = '{8'hE2, 8'h80};
      send_word();
   endtask

   task test_random_words();
      run_random_words(RANDOM_BYTES);
   endtask

   // back-to-back beats with ready held high
   task test_streaming();
      calm = 1'b1;
      run_random_words(STREAM_BYTES);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_words();
      test_streaming();

      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      // the watchdog bounds this wait
      do @(negedge clock); while (folded_beats_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (folded_beats_due.size() != 0) begin
         $error("%0d result beats never arrived", folded_beats_due.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
